[design/llh_pkg.sv]
// Shared types, constants and configuration codes for the log-linear histogram.
package llh_pkg;

  localparam int SAMPLE_W     = 32;
  localparam int SUM_W        = 48;
  localparam int FRAC_BITS    = 8;
  localparam int OCTAVES      = 32;
  localparam int SUB_BITS_MAX = 4;
  localparam int COUNT_W      = 32;
  localparam int BIN_W        = 9;
  localparam int NBINS        = OCTAVES << SUB_BITS_MAX;
  localparam int OCT_W        = $clog2(OCTAVES);
  localparam int RND_W        = SUM_W - FRAC_BITS + 1;
  localparam int SHAMT_W      = $clog2(SUM_W + SUB_BITS_MAX + 1);
  localparam int WIDE_W       = SUM_W + SUB_BITS_MAX;
  localparam int GSIZE_W      = 17;
  localparam int SUBB_W       = 3;
  localparam int CFG_IDX_W    = 1;
  localparam int CFG_DATA_W   = 17;
  localparam int Q_DEPTH      = 4;
  localparam int Q_PTR_W      = $clog2(Q_DEPTH);
  localparam int MEM_W        = COUNT_W + 2 * SUM_W;

  localparam logic [CFG_IDX_W-1:0] CFG_GROUP_SIZE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SUB_BITS   = 1'b1;

  localparam logic OP_ADD  = 1'b0;
  localparam logic OP_READ = 1'b1;

  localparam logic [SUBB_W-1:0] SUB_BITS_LIMIT = SUBB_W'(SUB_BITS_MAX);

  typedef enum logic [1:0] {
    K_READ,
    K_REJECT,
    K_ADD,
    K_CLOSE
  } kind_t;

  typedef struct packed {
    logic                operation;
    logic [SAMPLE_W-1:0] sample_value;
    logic [BIN_W-1:0]    read_bin;
  } in_t;

  typedef struct packed {
    logic               accepted;
    logic               group_closed;
    logic [BIN_W-1:0]   bin_index;
    logic [COUNT_W-1:0] bin_count;
    logic [SUM_W-1:0]   bin_low;
    logic [SUM_W-1:0]   bin_high;
    logic               bin_empty;
  } out_t;

  typedef struct packed {
    kind_t            kind;
    logic [SUM_W-1:0] value;
  } qent_t;

  typedef struct packed {
    logic             valid;
    kind_t            kind;
    logic [SUM_W-1:0] sum;
    logic [BIN_W-1:0] idx;
  } iss_t;

  typedef struct packed {
    logic adv;
    logic clearing;
  } bin_ctrl_t;

endpackage

[design/llh_front.sv]
// Front end: accepts words, accumulates group sums and classifies each word.
module llh_front import llh_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               acc,
  input  in_t                in_data,
  input  logic [GSIZE_W-1:0] group_size,
  output logic               push,
  output qent_t              enq_word
);

  logic [SUM_W-1:0]   sum_r;
  logic [SUM_W-1:0]   sum_nxt;
  logic [GSIZE_W-1:0] fill_r;
  logic [GSIZE_W-1:0] fill_nxt;
  logic [SUM_W:0]     add_w;
  logic [SUM_W-1:0]   sat_sum;
  logic [GSIZE_W-1:0] fill_inc;
  logic [GSIZE_W-1:0] size;
  logic               close;

  assign add_w    = (SUM_W + 1)'(sum_r) + (SUM_W + 1)'(in_data.sample_value);
  assign sat_sum  = add_w[SUM_W] ? '1 : add_w[SUM_W-1:0];
  assign fill_inc = fill_r + GSIZE_W'(1);
  assign size     = (group_size == '0) ? GSIZE_W'(1) : group_size;
  assign close    = (fill_inc >= size);
  assign push     = acc;

  always_comb begin
    sum_nxt        = sum_r;
    fill_nxt       = fill_r;
    enq_word.kind  = K_REJECT;
    enq_word.value = '0;
    if (in_data.operation == OP_READ) begin
      enq_word.kind  = K_READ;
      enq_word.value = SUM_W'(in_data.read_bin);
    end else if (in_data.sample_value != '0) begin
      if (close) begin
        enq_word.kind  = K_CLOSE;
        enq_word.value = sat_sum;
        sum_nxt        = '0;
        fill_nxt       = '0;
      end else begin
        enq_word.kind = K_ADD;
        sum_nxt       = sat_sum;
        fill_nxt      = fill_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r  <= '0;
      fill_r <= '0;
    end else if (acc) begin
      sum_r  <= sum_nxt;
      fill_r <= fill_nxt;
    end
  end

endmodule

[design/llh_queue.sv]
// Short queue that decouples the front end from the bin update pipeline.
module llh_queue import llh_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  qent_t enq_word,
  input  logic  pop,
  output logic  full,
  output logic  head_valid,
  output qent_t head
);

  qent_t              slots [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r;
  logic [Q_PTR_W-1:0] rd_ptr_r;
  logic [Q_PTR_W:0]   cnt_r;
  logic [Q_PTR_W:0]   cnt_nxt;

  assign full       = (cnt_r == (Q_PTR_W + 1)'(Q_DEPTH));
  assign head_valid = (cnt_r != '0);
  assign head       = slots[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + (Q_PTR_W + 1)'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - (Q_PTR_W + 1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr_r] <= enq_word;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + Q_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + Q_PTR_W'(1);
      end
    end
  end

endmodule

[design/llh_index.sv]
// Bin index pipeline: rounding, octave search, offset and sub-bucket selection.
module llh_index import llh_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              adv,
  input  logic              head_valid,
  input  qent_t             head,
  input  logic [SUBB_W-1:0] sub_bits,
  output logic              pop,
  output iss_t              iss
);

  logic             v1_r, v2_r, v3_r;
  kind_t            k1_r, k2_r, k3_r;
  logic [SUM_W-1:0] s1_r, s2_r, s3_r;
  logic [RND_W-1:0] r1_r;
  logic [OCT_W-1:0] oct2_r, oct3_r;
  logic [SUM_W-1:0] diff3_r;

  logic             rnd_inc;
  logic [RND_W-1:0] r1_nxt;
  logic [OCT_W-1:0] oct_nxt;
  logic [SUM_W-1:0] base;
  logic [SUM_W-1:0] diff_nxt;

  logic [SUBB_W-1:0]       sb;
  logic [WIDE_W-1:0]       wide;
  logic [WIDE_W-1:0]       shr;
  logic [SUB_BITS_MAX-1:0] submax;
  logic [SUB_BITS_MAX-1:0] sub;
  logic [BIN_W-1:0]        idx;

  assign pop = adv && head_valid;

  // Round to nearest with ties to even, then add one for the octave search.
  assign rnd_inc = head.value[FRAC_BITS-1]
                   && ((|head.value[FRAC_BITS-2:0]) || head.value[FRAC_BITS]);
  assign r1_nxt  = RND_W'(head.value >> FRAC_BITS) + (rnd_inc ? RND_W'(2) : RND_W'(1));

  always_comb begin
    oct_nxt = '0;
    for (int i = 0; i < OCTAVES; i++) begin
      if (r1_r[i]) begin
        oct_nxt = OCT_W'(i);
      end
    end
    if (|r1_r[RND_W-1:OCTAVES-1]) begin
      oct_nxt = OCT_W'(OCTAVES - 1);
    end
  end

  assign base     = ((SUM_W'(1) << oct2_r) - SUM_W'(1)) << FRAC_BITS;
  assign diff_nxt = (s2_r > base) ? (s2_r - base) : '0;

  assign sb     = (sub_bits > SUB_BITS_LIMIT) ? SUB_BITS_LIMIT : sub_bits;
  assign wide   = WIDE_W'(diff3_r) << sb;
  assign shr    = wide >> (SHAMT_W'(oct3_r) + SHAMT_W'(FRAC_BITS));
  assign submax = (SUB_BITS_MAX'(1) << sb) - SUB_BITS_MAX'(1);

  always_comb begin
    if ((|shr[WIDE_W-1:SUB_BITS_MAX]) || (shr[SUB_BITS_MAX-1:0] > submax)) begin
      sub = submax;
    end else begin
      sub = shr[SUB_BITS_MAX-1:0];
    end
    if (k3_r == K_READ) begin
      idx = s3_r[BIN_W-1:0];
    end else begin
      idx = (BIN_W'(oct3_r) << sb) | BIN_W'(sub);
    end
  end

  assign iss.valid = v3_r;
  assign iss.kind  = k3_r;
  assign iss.sum   = s3_r;
  assign iss.idx   = idx;

  always_ff @(posedge clk) begin
    if (adv) begin
      k1_r    <= head.kind;
      s1_r    <= head.value;
      r1_r    <= r1_nxt;
      k2_r    <= k1_r;
      s2_r    <= s1_r;
      oct2_r  <= oct_nxt;
      k3_r    <= k2_r;
      s3_r    <= s2_r;
      oct3_r  <= oct2_r;
      diff3_r <= diff_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (adv) begin
      v1_r <= pop;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

endmodule

[design/llh_bins.sv]
// Bin store with read-modify-write, forwarding, clearing pass and output register.
module llh_bins import llh_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  iss_t      iss,
  input  logic      out_stall,
  output bin_ctrl_t ctrl,
  output logic      out_valid,
  output out_t      out_data
);

  localparam logic [MEM_W-1:0] CLEAR_WORD = {{COUNT_W{1'b0}}, {SUM_W{1'b1}}, {SUM_W{1'b0}}};

  logic [MEM_W-1:0] mem [NBINS];
  logic [MEM_W-1:0] mem_q_r;

  logic             clearing_r;
  logic [BIN_W-1:0] clr_cnt_r;

  logic             v5_r;
  kind_t            k5_r;
  logic [SUM_W-1:0] s5_r;
  logic [BIN_W-1:0] idx5_r;

  logic             lw_valid_r;
  logic [BIN_W-1:0] lw_addr_r;
  logic [MEM_W-1:0] lw_data_r;

  logic             out_valid_r;
  out_t             out_data_r;

  logic               adv;
  logic [MEM_W-1:0]   old_word;
  logic [COUNT_W-1:0] old_cnt;
  logic [SUM_W-1:0]   old_min;
  logic [SUM_W-1:0]   old_max;
  logic [COUNT_W-1:0] new_cnt;
  logic [SUM_W-1:0]   new_min;
  logic [SUM_W-1:0]   new_max;
  logic [MEM_W-1:0]   new_word;
  logic               upd;
  logic               wr_en;
  logic [BIN_W-1:0]   wr_addr;
  logic [MEM_W-1:0]   wr_data;
  out_t               res;

  assign adv           = !clearing_r && (!out_valid_r || !out_stall);
  assign ctrl.adv      = adv;
  assign ctrl.clearing = clearing_r;
  assign out_valid     = out_valid_r;
  assign out_data      = out_data_r;

  // The update leaving this stage is not yet in the read data of the next one.
  assign old_word = (lw_valid_r && (lw_addr_r == idx5_r)) ? lw_data_r : mem_q_r;
  assign old_cnt  = old_word[MEM_W-1 -: COUNT_W];
  assign old_min  = old_word[2*SUM_W-1 -: SUM_W];
  assign old_max  = old_word[SUM_W-1:0];

  assign new_cnt  = (old_cnt == '1) ? old_cnt : old_cnt + COUNT_W'(1);
  assign new_min  = (s5_r < old_min) ? s5_r : old_min;
  assign new_max  = (s5_r > old_max) ? s5_r : old_max;
  assign new_word = {new_cnt, new_min, new_max};

  assign upd     = adv && v5_r && (k5_r == K_CLOSE);
  assign wr_en   = clearing_r || upd;
  assign wr_addr = clearing_r ? clr_cnt_r : idx5_r;
  assign wr_data = clearing_r ? CLEAR_WORD : new_word;

  always_comb begin
    res = '0;
    case (k5_r)
      K_READ: begin
        res.bin_index = idx5_r;
        res.bin_count = old_cnt;
        res.bin_low   = old_min;
        res.bin_high  = old_max;
        res.bin_empty = (old_cnt == '0);
      end
      K_CLOSE: begin
        res.accepted     = 1'b1;
        res.group_closed = 1'b1;
        res.bin_index    = idx5_r;
        res.bin_count    = new_cnt;
        res.bin_low      = new_min;
        res.bin_high     = new_max;
        res.bin_empty    = (new_cnt == '0);
      end
      K_ADD: begin
        res.accepted = 1'b1;
      end
      default: begin
        res = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (adv) begin
      mem_q_r <= mem[iss.idx];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      k5_r      <= iss.kind;
      s5_r      <= iss.sum;
      idx5_r    <= iss.idx;
      lw_addr_r <= idx5_r;
      lw_data_r <= new_word;
    end
    if (adv && v5_r) begin
      out_data_r <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r  <= 1'b1;
      clr_cnt_r   <= '0;
      v5_r        <= 1'b0;
      lw_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (clearing_r) begin
        clr_cnt_r <= clr_cnt_r + BIN_W'(1);
        if (clr_cnt_r == BIN_W'(NBINS - 1)) begin
          clearing_r <= 1'b0;
        end
      end
      if (adv) begin
        v5_r        <= iss.valid;
        lw_valid_r  <= upd;
        out_valid_r <= v5_r;
      end
    end
  end

endmodule

[design/log_linear_histogram_core.sv]
// Log-linear histogram of grouped sample sums with 512 bins and sub-buckets.
// The in_ channel carries one word per add or read; the out_ channel returns
// exactly one result word for every accepted input word, in order. Both use
// valid and stall, and a word moves on an edge with valid high and stall low.
// The cfg_ channel writes group_size (index 0) and sub_bits (index 1); it is
// always ready and is meant to be used while the block is idle.
// An accepted word passes the queue, the index registers, the bin stage and
// the output register before out_valid rises. One word per cycle is taken and
// delivered in steady state when nothing stalls; the read-modify-write of the
// bin memory sets the rate and forwards the previous update to a following hit
// on the same bin. After reset a clearing pass runs over all 512 bins, holding
// in_stall high; configuration writes are taken meanwhile.
// When the receiver stalls, the result pipeline holds and a four-word queue
// keeps taking input until it fills, then in_stall rises.
module log_linear_histogram_core import llh_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_t                   in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_t                  out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic [GSIZE_W-1:0] group_size_r;
  logic [SUBB_W-1:0]  sub_bits_r;

  logic      acc;
  logic      push;
  qent_t     enq_word;
  logic      pop;
  logic      q_full;
  logic      head_valid;
  qent_t     head;
  iss_t      iss;
  bin_ctrl_t ctrl;

  assign cfg_ready = 1'b1;
  assign in_stall  = ctrl.clearing || q_full;
  assign acc       = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      group_size_r <= GSIZE_W'(1);
      sub_bits_r   <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_GROUP_SIZE: group_size_r <= cfg_data[GSIZE_W-1:0];
        CFG_SUB_BITS:   sub_bits_r   <= cfg_data[SUBB_W-1:0];
        default: begin
        end
      endcase
    end
  end

  llh_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .acc        (acc),
    .in_data    (in_data),
    .group_size (group_size_r),
    .push       (push),
    .enq_word   (enq_word)
  );

  llh_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .enq_word   (enq_word),
    .pop        (pop),
    .full       (q_full),
    .head_valid (head_valid),
    .head       (head)
  );

  llh_index u_index (
    .clk        (clk),
    .rst_n      (rst_n),
    .adv        (ctrl.adv),
    .head_valid (head_valid),
    .head       (head),
    .sub_bits   (sub_bits_r),
    .pop        (pop),
    .iss        (iss)
  );

  llh_bins u_bins (
    .clk       (clk),
    .rst_n     (rst_n),
    .iss       (iss),
    .out_stall (out_stall),
    .ctrl      (ctrl),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

[verif/tb_log_linear_histogram_core.sv]
// Self-checking testbench for the log-linear histogram core with a bin-tracking scoreboard.
`timescale 1ns / 1ps

module tb_log_linear_histogram_core;
  import llh_pkg::*;

  typedef enum {PACE_SLOW_SINK, PACE_SLOW_SOURCE, PACE_FULL} pace_t;

  class hist_tracker;
    bit [GSIZE_W-1:0] group_size;
    bit [SUBB_W-1:0]  sub_bits;
    bit [SUM_W-1:0]   group_sum;
    bit [GSIZE_W-1:0] group_fill;
    bit [COUNT_W-1:0] bin_count [NBINS];
    bit [SUM_W-1:0]   bin_low [NBINS];
    bit [SUM_W-1:0]   bin_high [NBINS];
    out_t             expected_words [$];
    int unsigned      hit_bins [$];
    int               errors;

    function new();
      group_size = 1;
      sub_bits   = 0;
      group_sum  = 0;
      group_fill = 0;
      errors     = 0;
      foreach (bin_count[i]) begin
        bin_count[i] = 0;
        bin_low[i]   = '1;
        bin_high[i]  = 0;
      end
    endfunction

    function void write_reg(bit [CFG_IDX_W-1:0] idx, bit [CFG_DATA_W-1:0] data);
      if (idx == CFG_GROUP_SIZE) begin
        group_size = data[GSIZE_W-1:0];
      end else begin
        sub_bits = data[SUBB_W-1:0];
      end
    endfunction

    function out_t bin_word(int unsigned b);
      out_t w;
      w           = '0;
      w.bin_index = b[BIN_W-1:0];
      w.bin_count = bin_count[b];
      w.bin_low   = bin_low[b];
      w.bin_high  = bin_high[b];
      w.bin_empty = (bin_count[b] == 0);
      return w;
    endfunction

    function void note_word(in_t w);
      out_t          r;
      bit [SUM_W:0]  total;
      bit [63:0]     s, rnd, rem, x, base, diff, sub, submax;
      int unsigned   oct, sb, idx, size;
      r = '0;
      if (w.operation == OP_READ) begin
        r = bin_word(w.read_bin);
      end else if (w.sample_value != 0) begin
        total      = {1'b0, group_sum} + w.sample_value;
        group_sum  = total[SUM_W] ? '1 : total[SUM_W-1:0];
        group_fill = group_fill + 1'b1;
        size       = (group_size == 0) ? 1 : group_size;
        if (group_fill >= size) begin
          s   = group_sum;
          rnd = s >> FRAC_BITS;
          rem = s & ((64'd1 << FRAC_BITS) - 1);
          if (rem > (64'd1 << (FRAC_BITS - 1)) ||
              (rem == (64'd1 << (FRAC_BITS - 1)) && rnd[0])) begin
            rnd++;
          end
          x   = rnd + 1;
          oct = 0;
          while (x > 1) begin
            x = x >> 1;
            oct++;
          end
          if (oct > OCTAVES - 1) oct = OCTAVES - 1;
          sb     = (sub_bits > SUB_BITS_MAX) ? SUB_BITS_MAX : sub_bits;
          base   = ((64'd1 << oct) - 1) << FRAC_BITS;
          diff   = (s > base) ? s - base : 64'd0;
          sub    = (diff << sb) >> (oct + FRAC_BITS);
          submax = (64'd1 << sb) - 1;
          if (sub > submax) sub = submax;
          idx = (oct << sb) | 32'(sub);
          if (bin_count[idx] != '1) bin_count[idx]++;
          if (s < bin_low[idx]) bin_low[idx] = SUM_W'(s);
          if (s > bin_high[idx]) bin_high[idx] = SUM_W'(s);
          group_sum      = 0;
          group_fill     = 0;
          r              = bin_word(idx);
          r.group_closed = 1'b1;
          hit_bins.push_back(idx);
          if (hit_bins.size() > 64) void'(hit_bins.pop_front());
        end
        r.accepted = 1'b1;
      end
      expected_words.push_back(r);
    endfunction

    function bit field_ok(string name, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
        $display("%0t: %s expected %h actual %h", $time, name, want, got);
        return 0;
      end
      return 1;
    endfunction

    function void match_result(out_t got);
      out_t want;
      bit   ok;
      if (expected_words.size() == 0) begin
        $display("%0t: result word with nothing expected, actual %h", $time, got);
        errors++;
        return;
      end
      want = expected_words.pop_front();
      ok   = 1;
      ok &= field_ok("accepted", want.accepted, got.accepted);
      ok &= field_ok("group_closed", want.group_closed, got.group_closed);
      ok &= field_ok("bin_index", want.bin_index, got.bin_index);
      ok &= field_ok("bin_count", want.bin_count, got.bin_count);
      ok &= field_ok("bin_low", want.bin_low, got.bin_low);
      ok &= field_ok("bin_high", want.bin_high, got.bin_high);
      ok &= field_ok("bin_empty", want.bin_empty, got.bin_empty);
      if (!ok) errors++;
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  in_t                   in_data = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_t                  out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  hist_tracker book = new();
  int          send_gap_pct = 0;
  int          recv_stall_pct = 0;
  int          hold_reqs = 0;
  int          hold_seen = 0;
  int          hold_left = 0;

  log_linear_histogram_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("Some tests failed");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) book.match_result(out_data);
    if (hold_seen != hold_reqs && hold_left == 0) begin
      hold_left = 60;
      hold_seen = hold_reqs;
    end
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  task automatic set_pace(input pace_t p);
    case (p)
      PACE_SLOW_SINK: begin
        send_gap_pct   = 32;
        recv_stall_pct = 81;
      end
      PACE_SLOW_SOURCE: begin
        send_gap_pct   = 81;
        recv_stall_pct = 32;
      end
      default: begin
        send_gap_pct   = 0;
        recv_stall_pct = 0;
      end
    endcase
  endtask

  function automatic in_t make_word(logic op, logic [SAMPLE_W-1:0] sample, int unsigned b);
    in_t w;
    w.operation    = op;
    w.sample_value = sample;
    w.read_bin     = b[BIN_W-1:0];
    return w;
  endfunction

  function automatic in_t random_word();
    int unsigned           pick, bits;
    logic [SAMPLE_W-1:0]   v;
    pick = $urandom_range(99);
    if (pick < 18) begin
      if (book.hit_bins.size() != 0 && $urandom_range(1) == 1) begin
        return make_word(OP_READ, $urandom,
                         book.hit_bins[$urandom_range(book.hit_bins.size() - 1)]);
      end
      return make_word(OP_READ, $urandom, $urandom_range(NBINS - 1));
    end
    if (pick < 22) return make_word(OP_ADD, '0, $urandom_range(NBINS - 1));
    bits = $urandom_range(SAMPLE_W, 1);
    v    = $urandom >> (SAMPLE_W - bits);
    if ($urandom_range(9) == 0) v[7:0] = 8'h80;
    if (v == 0) v = 1;
    return make_word(OP_ADD, v, $urandom_range(NBINS - 1));
  endfunction

  task automatic push_word(input in_t w);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    book.note_word(w);
  endtask

  task automatic await_drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (book.expected_words.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value[CFG_DATA_W-1:0];
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    book.write_reg(idx, value[CFG_DATA_W-1:0]);
  endtask

  task automatic configure(input int unsigned gsize, input int unsigned sbits);
    write_register(CFG_GROUP_SIZE, gsize);
    write_register(CFG_SUB_BITS, sbits);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    int unsigned gsizes [6] = '{0, 1, 2, 40, 3, 1};
    int unsigned sbits [6]  = '{0, 4, 1, 4, 2, 5};
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    set_pace(PACE_FULL);

    push_word(make_word(OP_ADD, 32'h1, 0));
    push_word(make_word(OP_ADD, 32'h80, 0));
    push_word(make_word(OP_ADD, 32'h180, 0));
    push_word(make_word(OP_ADD, 32'h17F, 0));
    push_word(make_word(OP_ADD, 32'h181, 0));
    push_word(make_word(OP_ADD, 32'h0, NBINS - 1));
    push_word(make_word(OP_ADD, 32'hFFFF_FFFF, 0));
    push_word(make_word(OP_READ, 32'h0, 0));
    push_word(make_word(OP_READ, 32'h0, 24));
    push_word(make_word(OP_READ, 32'h0, NBINS - 1));
    push_word(make_word(OP_READ, 32'hFFFF_FFFF, 1));

    await_drain();
    configure(2, 7);
    push_word(make_word(OP_ADD, 32'hFFFF_FFFF, 0));
    push_word(make_word(OP_ADD, 32'hFFFF_FFFF, 0));
    push_word(make_word(OP_ADD, 32'h100, 0));
    push_word(make_word(OP_ADD, 32'h300, 0));
    push_word(make_word(OP_ADD, 32'h141, 0));
    push_word(make_word(OP_ADD, 32'h140, 0));
    push_word(make_word(OP_READ, 32'h0, 32));

    await_drain();
    configure(65536, 7);
    push_word(make_word(OP_ADD, 32'h5, 0));
    push_word(make_word(OP_ADD, 32'h1000, 0));
    push_word(make_word(OP_ADD, 32'h12345, 0));
    await_drain();
    configure(2, 7);
    push_word(make_word(OP_ADD, 32'h7, 0));
    push_word(make_word(OP_READ, 32'h0, book.hit_bins[book.hit_bins.size() - 1]));

    for (int p = 0; p < 6; p++) begin
      await_drain();
      configure(gsizes[p], sbits[p]);
      set_pace(PACE_SLOW_SINK);
      hold_reqs++;
      for (int n = 0; n < 270; n++) begin
        if (n == 90) set_pace(PACE_SLOW_SOURCE);
        if (n == 180) set_pace(PACE_FULL);
        push_word(random_word());
      end
    end

    // A group size of 65537 keeps the group open through these twenty adds until the size is lowered.
    await_drain();
    configure(65537, 4);
    set_pace(PACE_FULL);
    for (int n = 0; n < 20; n++) begin
      push_word(make_word(OP_ADD, 32'hFFFF_FFFF, 0));
    end
    await_drain();
    configure(1, 4);
    push_word(make_word(OP_ADD, 32'hFFFF_FFFF, 0));
    push_word(make_word(OP_READ, 32'h0, book.hit_bins[book.hit_bins.size() - 1]));
    push_word(make_word(OP_READ, 32'h0, NBINS - 1));

    await_drain();
    repeat (16) @(posedge clk);
    if (book.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
